### src/i2p_pkg.sv
package i2p_pkg;

   localparam int KindW       = 4;
   localparam int RefPortW    = 16;
   localparam int StatusW     = 2;
   localparam int TotalW      = 16;
   localparam int PrecW       = 3;
   localparam int DefStackDepth = 32;
   localparam int DefRefBits    = 16;

   localparam logic [KindW-1:0] K_OPERAND = 4'd0;
   localparam logic [KindW-1:0] K_LPAREN  = 4'd1;
   localparam logic [KindW-1:0] K_RPAREN  = 4'd2;
   localparam logic [KindW-1:0] K_SIN     = 4'd3;
   localparam logic [KindW-1:0] K_COS     = 4'd4;
   localparam logic [KindW-1:0] K_TAN     = 4'd5;
   localparam logic [KindW-1:0] K_COT     = 4'd6;
   localparam logic [KindW-1:0] K_ADD     = 4'd7;
   localparam logic [KindW-1:0] K_SUB     = 4'd8;
   localparam logic [KindW-1:0] K_MUL     = 4'd9;
   localparam logic [KindW-1:0] K_DIV     = 4'd10;
   localparam logic [KindW-1:0] K_POW     = 4'd11;

   localparam logic CMD_TOKEN = 1'b0;
   localparam logic CMD_END   = 1'b1;

   localparam logic [StatusW-1:0] ST_OK        = 2'd0;
   localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [StatusW-1:0] ST_UNMATCHED = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_RPFUNC
   } state_type;

   typedef enum logic [2:0] {
      A_END,
      A_WAIT,
      A_POP,
      A_EMIT,
      A_STATUS,
      A_SUMMARY,
      A_PUSH,
      A_DROP
   } action_type;

   typedef struct packed {
      logic                is_token;
      logic [KindW-1:0]    out_kind;
      logic [RefPortW-1:0] out_ref;
      logic [StatusW-1:0]  status;
      logic [TotalW-1:0]   emitted_total;
   } item_type;

   function automatic logic is_func(input logic [KindW-1:0] kind);
      return (kind == K_SIN) || (kind == K_COS) || (kind == K_TAN) || (kind == K_COT);
   endfunction

   function automatic logic [PrecW-1:0] prec_of(input logic [KindW-1:0] kind);
      logic [PrecW-1:0] p;
      case (kind)
         K_SIN, K_COS, K_TAN, K_COT: p = 3'd4;
         K_POW:                      p = 3'd3;
         K_MUL, K_DIV:               p = 3'd2;
         K_ADD, K_SUB:               p = 3'd1;
         default:                    p = 3'd0;
      endcase
      return p;
   endfunction

endpackage

### src/i2p_if.sv
interface i2p_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [i2p_pkg::KindW-1:0]     token_kind;
   logic [i2p_pkg::RefPortW-1:0]  token_ref;

   modport source(output valid, cmd, token_kind, token_ref, input ready);
   modport sink(input valid, cmd, token_kind, token_ref, output ready);
endinterface

interface i2p_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_token;
   logic [i2p_pkg::KindW-1:0]     out_kind;
   logic [i2p_pkg::RefPortW-1:0]  out_ref;
   logic [i2p_pkg::StatusW-1:0]   status;
   logic [i2p_pkg::TotalW-1:0]    emitted_total;
   logic                          last;

   modport source(output valid, is_token, out_kind, out_ref, status, emitted_total, last,
                  input ready);
   modport sink(input valid, is_token, out_kind, out_ref, status, emitted_total, last,
                output ready);
endinterface

### src/i2p_ram.sv
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/infix_to_postfix_reorder_top.sv
// Infix-to-postfix reorder with an operator stack held in a single-port-write,
// registered-read RAM. One transaction is taken at a time: each stack pop is a
// step of its own (one RAM read of the new top), and a right paren that drops
// its left paren goes on to look at the entry below, in which a function found
// there is popped as well; an end command pops its entries one at a time.
// Results leave through a one-item hold register and an output register, so a
// slow response side can stall these steps. The stack needs no clearing after
// reset.
module infix_to_postfix_reorder_top #(
   parameter int STACK_DEPTH = i2p_pkg::DefStackDepth,
   parameter int REF_BITS    = i2p_pkg::DefRefBits
) (
   input  logic           clock,
   input  logic           reset,
   i2p_req_if.sink        req_chan,
   i2p_rsp_if.source      rsp_chan
);

   localparam int RefW  = (REF_BITS < i2p_pkg::RefPortW) ? REF_BITS : i2p_pkg::RefPortW;
   localparam int EntW  = i2p_pkg::KindW + RefW;
   localparam int CntW  = $clog2(STACK_DEPTH + 1);
   localparam int AddrW = $clog2(STACK_DEPTH);

   i2p_pkg::state_type  state_ff, state_in;
   i2p_pkg::action_type act;

   logic                        tok_cmd_ff, tok_cmd_in;
   logic [i2p_pkg::KindW-1:0]   tok_kind_ff, tok_kind_in;
   logic [RefW-1:0]             tok_ref_ff, tok_ref_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic [i2p_pkg::TotalW-1:0]  emit_ff, emit_in;
   logic                        pend_valid_ff, pend_valid_in;
   i2p_pkg::item_type           pend_ff, pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   i2p_pkg::item_type           rsp_item_ff, rsp_item_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        wr_en;
   logic [AddrW-1:0]            wr_addr;
   logic [EntW-1:0]             wr_data;
   logic [AddrW-1:0]            rd_addr;
   logic [EntW-1:0]             rd_data;
   logic [CntW-1:0]             cnt_dec;

   logic [i2p_pkg::KindW-1:0]   top_kind;
   logic [RefW-1:0]             top_ref;
   logic                        has_top;
   logic                        full;
   logic                        out_free;
   logic                        accept;
   i2p_pkg::item_type           new_item;
   i2p_pkg::action_type         want;

   i2p_ram #(
      .WIDTH(EntW),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign top_kind = rd_data[EntW-1 -: i2p_pkg::KindW];
   assign top_ref  = rd_data[RefW-1:0];
   assign has_top  = (cnt_ff != '0);
   assign full     = (cnt_ff == CntW'(STACK_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == i2p_pkg::S_IDLE) && (!pend_valid_ff || out_free);
   assign accept   = req_chan.valid && req_chan.ready;

   // action decode
   always_comb begin
      want     = i2p_pkg::A_END;
      new_item = '0;
      case (state_ff)
         i2p_pkg::S_EVAL: begin
            if (tok_cmd_ff == i2p_pkg::CMD_END) begin
               if (has_top && top_kind != i2p_pkg::K_LPAREN) begin
                  want = i2p_pkg::A_POP;
               end else begin
                  want = i2p_pkg::A_SUMMARY;
               end
            end else begin
               case (tok_kind_ff)
                  i2p_pkg::K_OPERAND: want = i2p_pkg::A_EMIT;
                  i2p_pkg::K_LPAREN, i2p_pkg::K_SIN, i2p_pkg::K_COS,
                  i2p_pkg::K_TAN, i2p_pkg::K_COT: begin
                     want = full ? i2p_pkg::A_STATUS : i2p_pkg::A_PUSH;
                  end
                  i2p_pkg::K_RPAREN: begin
                     if (!has_top) begin
                        want = i2p_pkg::A_STATUS;
                     end else if (top_kind != i2p_pkg::K_LPAREN) begin
                        want = i2p_pkg::A_POP;
                     end else begin
                        want = i2p_pkg::A_DROP;
                     end
                  end
                  i2p_pkg::K_ADD, i2p_pkg::K_SUB, i2p_pkg::K_MUL,
                  i2p_pkg::K_DIV, i2p_pkg::K_POW: begin
                     if (has_top
                         && i2p_pkg::prec_of(top_kind) >= i2p_pkg::prec_of(tok_kind_ff)
                         && !(top_kind == i2p_pkg::K_POW && tok_kind_ff == i2p_pkg::K_POW))
                     begin
                        want = i2p_pkg::A_POP;
                     end else begin
                        want = full ? i2p_pkg::A_STATUS : i2p_pkg::A_PUSH;
                     end
                  end
                  default: want = i2p_pkg::A_END;
               endcase
            end
         end
         i2p_pkg::S_RPFUNC: begin
            if (has_top && i2p_pkg::is_func(top_kind)) begin
               want = i2p_pkg::A_POP;
            end
         end
         default: want = i2p_pkg::A_END;
      endcase

      case (want)
         i2p_pkg::A_POP: begin
            new_item.is_token = 1'b1;
            new_item.out_kind = top_kind;
            new_item.out_ref  = i2p_pkg::RefPortW'(top_ref);
         end
         i2p_pkg::A_EMIT: begin
            new_item.is_token = 1'b1;
            new_item.out_kind = tok_kind_ff;
            new_item.out_ref  = i2p_pkg::RefPortW'(tok_ref_ff);
         end
         i2p_pkg::A_STATUS: begin
            new_item.out_kind = tok_kind_ff;
            new_item.out_ref  = i2p_pkg::RefPortW'(tok_ref_ff);
            new_item.status   = (tok_kind_ff == i2p_pkg::K_RPAREN) ? i2p_pkg::ST_UNMATCHED
                                                                   : i2p_pkg::ST_OVERFLOW;
         end
         i2p_pkg::A_SUMMARY: begin
            new_item.emitted_total = emit_ff;
         end
         default: new_item = '0;
      endcase

      act = want;
      if ((want == i2p_pkg::A_POP || want == i2p_pkg::A_EMIT || want == i2p_pkg::A_STATUS
           || want == i2p_pkg::A_SUMMARY) && pend_valid_ff && !out_free) begin
         act = i2p_pkg::A_WAIT;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2p_pkg::S_IDLE: begin
            if (accept) begin
               state_in = i2p_pkg::S_EVAL;
            end
         end
         i2p_pkg::S_EVAL: begin
            case (act)
               i2p_pkg::A_WAIT, i2p_pkg::A_POP: state_in = i2p_pkg::S_EVAL;
               i2p_pkg::A_DROP:                 state_in = i2p_pkg::S_RPFUNC;
               default:                         state_in = i2p_pkg::S_IDLE;
            endcase
         end
         i2p_pkg::S_RPFUNC: begin
            if (act != i2p_pkg::A_WAIT) begin
               state_in = i2p_pkg::S_IDLE;
            end
         end
         default: state_in = i2p_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      tok_cmd_in    = tok_cmd_ff;
      tok_kind_in   = tok_kind_ff;
      tok_ref_in    = tok_ref_ff;
      cnt_in        = cnt_ff;
      emit_in       = emit_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[AddrW-1:0];
      wr_data       = {tok_kind_ff, tok_ref_ff};

      if (state_ff == i2p_pkg::S_IDLE) begin
         if (pend_valid_ff && out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_item_in   = pend_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
         if (accept) begin
            tok_cmd_in  = req_chan.cmd;
            tok_kind_in = req_chan.token_kind;
            tok_ref_in  = req_chan.token_ref[RefW-1:0];
         end
      end else begin
         case (act)
            i2p_pkg::A_POP: begin
               cnt_in = cnt_ff - CntW'(1);
               if (emit_ff != '1) begin
                  emit_in = emit_ff + i2p_pkg::TotalW'(1);
               end
            end
            i2p_pkg::A_EMIT: begin
               if (emit_ff != '1) begin
                  emit_in = emit_ff + i2p_pkg::TotalW'(1);
               end
            end
            i2p_pkg::A_SUMMARY: begin
               cnt_in  = '0;
               emit_in = '0;
            end
            i2p_pkg::A_PUSH: begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CntW'(1);
            end
            i2p_pkg::A_DROP: begin
               cnt_in = cnt_ff - CntW'(1);
            end
            default: cnt_in = cnt_ff;
         endcase
         if (act == i2p_pkg::A_POP || act == i2p_pkg::A_EMIT || act == i2p_pkg::A_STATUS
             || act == i2p_pkg::A_SUMMARY) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = pend_ff;
               rsp_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_in       = new_item;
         end
      end
   end

   // read the entry that will be on top after this cycle
   assign cnt_dec = cnt_in - CntW'(1);
   assign rd_addr = cnt_dec[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= i2p_pkg::S_IDLE;
         cnt_ff        <= '0;
         emit_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         emit_ff       <= emit_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_cmd_ff  <= tok_cmd_in;
      tok_kind_ff <= tok_kind_in;
      tok_ref_ff  <= tok_ref_in;
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.is_token      = rsp_item_ff.is_token;
   assign rsp_chan.out_kind      = rsp_item_ff.out_kind;
   assign rsp_chan.out_ref       = rsp_item_ff.out_ref;
   assign rsp_chan.status        = rsp_item_ff.status;
   assign rsp_chan.emitted_total = rsp_item_ff.emitted_total;
   assign rsp_chan.last          = rsp_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("push into full stack");

   a_summary_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff != i2p_pkg::S_IDLE && act == i2p_pkg::A_SUMMARY)
      |=> (cnt_ff == '0 && emit_ff == '0 && state_ff == i2p_pkg::S_IDLE))
      else $error("end of expression left state behind");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_valid_ff && !rsp_chan.ready) |=> pend_valid_ff)
      else $error("held result lost");

endmodule

### dv/tb_infix_to_postfix_reorder_top.sv
`timescale 1ns / 100ps

module tb_infix_to_postfix_reorder_top;

   localparam int                        STACK_SIZE   = i2p_pkg::DefStackDepth;
   localparam int                        RANDOM_ITEMS = 270;
   localparam int                        HOLD_CYCLES  = 240;
   localparam int                        QUIET_LIMIT  = 2000;
   localparam int                        DRAIN_CYCLES = 80;
   localparam int                        PLAN_ROWS    = 27;
   localparam logic [i2p_pkg::KindW-1:0] KIND_UNUSED  = 4'd15;

   typedef struct packed {
      i2p_pkg::item_type item;
      logic              last;
   } postfix_out_type;

   typedef struct packed {
      logic                         cmd;
      logic [i2p_pkg::KindW-1:0]    kind;
      logic [i2p_pkg::RefPortW-1:0] tag;
      logic                         typed;
      logic                         silent;
      postfix_out_type              want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   i2p_req_if req_chan ();
   i2p_rsp_if rsp_chan ();

   infix_to_postfix_reorder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [i2p_pkg::KindW-1:0]    stack_kind [STACK_SIZE];
   logic [i2p_pkg::RefPortW-1:0] stack_tag  [STACK_SIZE];
   int                           stack_depth;
   int                           emit_total;
   postfix_out_type              step_out [$];
   postfix_out_type              postfix_expect_q [$];

   int   mismatch_count = 0;
   int   items_sent     = 0;
   int   rsp_count      = 0;
   int   quiet_cycles   = 0;
   logic req_idle       = 1'b1;
   logic rsp_idle       = 1'b1;
   logic hold_off_req   = 1'b0;

   // sin ( a + cos ( b ^ c ^ d ) * tan ( e ) / - cot ) ( end
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{i2p_pkg::CMD_END,   i2p_pkg::K_LPAREN,  16'hFFFF, 1'b1, 1'b0,
        '{'{1'b0, i2p_pkg::K_OPERAND, 16'h0000, i2p_pkg::ST_OK, 16'd0}, 1'b1}},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, 16'hFFFF, 1'b1, 1'b0,
        '{'{1'b1, i2p_pkg::K_OPERAND, 16'hFFFF, i2p_pkg::ST_OK, 16'd0}, 1'b1}},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN,  16'h0000, 1'b1, 1'b0,
        '{'{1'b0, i2p_pkg::K_RPAREN, 16'h0000, i2p_pkg::ST_UNMATCHED, 16'd0}, 1'b1}},
      '{i2p_pkg::CMD_TOKEN, KIND_UNUSED,        16'h5A5A, 1'b1, 1'b1, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_SIN,     16'h0105, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_LPAREN,  16'h0106, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, 16'h0107, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_ADD,     16'h0108, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_COS,     16'h0109, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_LPAREN,  16'h010A, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, 16'h010B, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_POW,     16'h010C, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, 16'h010D, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_POW,     16'h010E, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, 16'h010F, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN,  16'h0110, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_MUL,     16'h0111, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_TAN,     16'h0112, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_LPAREN,  16'h0113, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, 16'h0114, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN,  16'h0115, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_DIV,     16'h0116, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_SUB,     16'h0117, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_COT,     16'h0118, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN,  16'h0119, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_TOKEN, i2p_pkg::K_LPAREN,  16'h011A, 1'b0, 1'b0, '0},
      '{i2p_pkg::CMD_END,   i2p_pkg::K_OPERAND, 16'h0000, 1'b0, 1'b0, '0}
   };

   function automatic int rank_of(input logic [i2p_pkg::KindW-1:0] k);
      if (k >= i2p_pkg::K_SIN && k <= i2p_pkg::K_COT) return 4;
      if (k == i2p_pkg::K_POW) return 3;
      if (k == i2p_pkg::K_MUL || k == i2p_pkg::K_DIV) return 2;
      if (k == i2p_pkg::K_ADD || k == i2p_pkg::K_SUB) return 1;
      return 0;
   endfunction

   function automatic logic is_trig(input logic [i2p_pkg::KindW-1:0] k);
      return k >= i2p_pkg::K_SIN && k <= i2p_pkg::K_COT;
   endfunction

   function automatic logic [i2p_pkg::RefPortW-1:0] rand_tag();
      return i2p_pkg::RefPortW'($urandom_range(0, 65535));
   endfunction

   function automatic logic [i2p_pkg::KindW-1:0] rand_kind(input int lo, input int hi);
      return i2p_pkg::KindW'($urandom_range(lo, hi));
   endfunction

   task automatic put_out(input logic tok, input logic [i2p_pkg::KindW-1:0] k,
                          input logic [i2p_pkg::RefPortW-1:0] t,
                          input logic [i2p_pkg::StatusW-1:0] st,
                          input logic [i2p_pkg::TotalW-1:0] total);
      postfix_out_type r;
      r.item.is_token      = tok;
      r.item.out_kind      = k;
      r.item.out_ref       = t;
      r.item.status        = st;
      r.item.emitted_total = total;
      r.last               = 1'b0;
      step_out.push_back(r);
   endtask

   task automatic emit_out(input logic [i2p_pkg::KindW-1:0] k,
                           input logic [i2p_pkg::RefPortW-1:0] t);
      if (emit_total < 65535) emit_total++;
      put_out(1'b1, k, t, i2p_pkg::ST_OK, '0);
   endtask

   task automatic pop_out();
      stack_depth--;
      emit_out(stack_kind[stack_depth], stack_tag[stack_depth]);
   endtask

   task automatic push_out(input logic [i2p_pkg::KindW-1:0] k,
                           input logic [i2p_pkg::RefPortW-1:0] t);
      if (stack_depth >= STACK_SIZE) begin
         put_out(1'b0, k, t, i2p_pkg::ST_OVERFLOW, '0);
      end else begin
         stack_kind[stack_depth] = k;
         stack_tag[stack_depth]  = t;
         stack_depth++;
      end
   endtask

   // shunting-yard step: fills step_out with the results of one transaction
   task automatic shunt_step(input logic c, input logic [i2p_pkg::KindW-1:0] k,
                             input logic [i2p_pkg::RefPortW-1:0] t);
      logic [i2p_pkg::KindW-1:0] top;
      step_out.delete();
      if (c == i2p_pkg::CMD_END) begin
         while (stack_depth > 0 && stack_kind[stack_depth-1] != i2p_pkg::K_LPAREN)
            pop_out();
         stack_depth = 0;
         put_out(1'b0, i2p_pkg::K_OPERAND, '0, i2p_pkg::ST_OK,
                 emit_total[i2p_pkg::TotalW-1:0]);
         emit_total = 0;
      end else if (k == i2p_pkg::K_OPERAND) begin
         emit_out(k, t);
      end else if (k == i2p_pkg::K_LPAREN || is_trig(k)) begin
         push_out(k, t);
      end else if (k == i2p_pkg::K_RPAREN) begin
         while (stack_depth > 0 && stack_kind[stack_depth-1] != i2p_pkg::K_LPAREN)
            pop_out();
         if (stack_depth == 0) begin
            put_out(1'b0, k, t, i2p_pkg::ST_UNMATCHED, '0);
         end else begin
            stack_depth--;
            if (stack_depth > 0 && is_trig(stack_kind[stack_depth-1])) pop_out();
         end
      end else if (k <= i2p_pkg::K_POW) begin
         while (stack_depth > 0) begin
            top = stack_kind[stack_depth-1];
            if (rank_of(top) < rank_of(k)) break;
            if (top == i2p_pkg::K_POW && k == i2p_pkg::K_POW) break;
            pop_out();
         end
         push_out(k, t);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("mismatch on result %0d: %s", rsp_count, what);
      mismatch_count++;
   endtask

   task automatic send_token(input logic c, input logic [i2p_pkg::KindW-1:0] k,
                             input logic [i2p_pkg::RefPortW-1:0] t, input logic typed,
                             input logic silent, input postfix_out_type want);
      int gap;
      gap = req_idle ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= c;
      req_chan.token_kind <= k;
      req_chan.token_ref  <= t;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      shunt_step(c, k, t);
      if (typed) begin
         if (!silent) postfix_expect_q.push_back(want);
      end else begin
         foreach (step_out[i]) postfix_expect_q.push_back(step_out[i]);
      end
      if (c == i2p_pkg::CMD_END || k <= i2p_pkg::K_POW) items_sent++;
   endtask

   task automatic send_plain(input logic c, input logic [i2p_pkg::KindW-1:0] k,
                             input logic [i2p_pkg::RefPortW-1:0] t);
      send_token(c, k, t, 1'b0, 1'b0, '0);
   endtask

   task automatic send_noise();
      logic                      c;
      logic [i2p_pkg::KindW-1:0] k;
      c = ($urandom_range(0, 7) == 0) ? i2p_pkg::CMD_END : i2p_pkg::CMD_TOKEN;
      k = rand_kind(0, 15);
      send_plain(c, k, rand_tag());
   endtask

   // well-formed expression with random content, now and then broken
   task automatic send_expression();
      int                        open_cnt;
      int                        operands;
      int                        target;
      int                        sel;
      logic                      want_operand;
      logic [i2p_pkg::KindW-1:0] k;
      open_cnt     = 0;
      operands     = 0;
      target       = $urandom_range(1, 10);
      want_operand = 1'b1;
      forever begin
         if ($urandom_range(0, 19) == 0) send_noise();
         sel = $urandom_range(0, 9);
         if (want_operand) begin
            if (sel < 6 || open_cnt >= 6) begin
               send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, rand_tag());
               operands++;
               want_operand = 1'b0;
            end else if (sel < 8) begin
               send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_LPAREN, rand_tag());
               open_cnt++;
            end else begin
               k = rand_kind(i2p_pkg::K_SIN, i2p_pkg::K_COT);
               send_plain(i2p_pkg::CMD_TOKEN, k, rand_tag());
               send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_LPAREN, rand_tag());
               open_cnt++;
            end
         end else begin
            if (open_cnt > 0 && sel < 3) begin
               send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN, rand_tag());
               open_cnt--;
            end else if (operands >= target) begin
               break;
            end else begin
               k = rand_kind(i2p_pkg::K_ADD, i2p_pkg::K_POW);
               send_plain(i2p_pkg::CMD_TOKEN, k, rand_tag());
               want_operand = 1'b1;
            end
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         repeat (open_cnt) send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN, rand_tag());
      end
      send_plain(i2p_pkg::CMD_END, rand_kind(0, 15), rand_tag());
   endtask

   // deep nesting that can run the stack into overflow
   task automatic send_nest();
      int                        n;
      logic [i2p_pkg::KindW-1:0] k;
      n = $urandom_range(28, 36);
      repeat (n) begin
         if ($urandom_range(0, 1) == 1) k = i2p_pkg::K_LPAREN;
         else k = rand_kind(i2p_pkg::K_SIN, i2p_pkg::K_COT);
         send_plain(i2p_pkg::CMD_TOKEN, k, rand_tag());
      end
      send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, rand_tag());
      k = rand_kind(i2p_pkg::K_ADD, i2p_pkg::K_POW);
      send_plain(i2p_pkg::CMD_TOKEN, k, rand_tag());
      send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_OPERAND, rand_tag());
      repeat ($urandom_range(0, n)) send_plain(i2p_pkg::CMD_TOKEN, i2p_pkg::K_RPAREN,
                                               rand_tag());
      send_plain(i2p_pkg::CMD_END, i2p_pkg::K_OPERAND, '0);
   endtask

   // stimulus
   initial begin
      int seqs;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = i2p_pkg::CMD_TOKEN;
      req_chan.token_kind = i2p_pkg::K_OPERAND;
      req_chan.token_ref  = '0;
      stack_depth         = 0;
      emit_total          = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         send_token(directed_plan[i].cmd, directed_plan[i].kind, directed_plan[i].tag,
                    directed_plan[i].typed, directed_plan[i].silent, directed_plan[i].want);
      end

      items_sent = 0;
      seqs       = 0;
      while (items_sent < RANDOM_ITEMS) begin
         req_idle = ($urandom_range(0, 3) != 0);
         if (seqs == 2) hold_off_req = 1'b1;
         if (seqs == 0 || $urandom_range(0, 11) == 0) send_nest();
         else send_expression();
         seqs++;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (postfix_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && postfix_expect_q.size() == 0) begin
         $display("infix_to_postfix_reorder_top test passed");
      end else begin
         $display("infix_to_postfix_reorder_top test failed");
      end
      $finish;
   end

   // result side
   initial begin
      int              gap;
      postfix_out_type got;
      postfix_out_type want;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_count % 32 == 0) rsp_idle = ($urandom_range(0, 2) != 0);
         gap = rsp_idle ? $urandom_range(0, 9) : 0;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got.item.is_token      = rsp_chan.is_token;
         got.item.out_kind      = rsp_chan.out_kind;
         got.item.out_ref       = rsp_chan.out_ref;
         got.item.status        = rsp_chan.status;
         got.item.emitted_total = rsp_chan.emitted_total;
         got.last               = rsp_chan.last;
         if (postfix_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction %h", got));
         end else begin
            want = postfix_expect_q.pop_front();
            if (got.item.is_token !== want.item.is_token)
               report_mismatch($sformatf("is_token %b want %b",
                                         got.item.is_token, want.item.is_token));
            if (got.item.out_kind !== want.item.out_kind)
               report_mismatch($sformatf("out_kind %0d want %0d",
                                         got.item.out_kind, want.item.out_kind));
            if (got.item.out_ref !== want.item.out_ref)
               report_mismatch($sformatf("out_ref %h want %h",
                                         got.item.out_ref, want.item.out_ref));
            if (got.item.status !== want.item.status)
               report_mismatch($sformatf("status %0d want %0d",
                                         got.item.status, want.item.status));
            if (got.item.emitted_total !== want.item.emitted_total)
               report_mismatch($sformatf("emitted_total %0d want %0d",
                                         got.item.emitted_total, want.item.emitted_total));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b want %b", got.last, want.last));
         end
         rsp_count++;
         @(negedge clock);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("infix_to_postfix_reorder_top test failed");
            $finish;
         end
      end
   end

endmodule

### sim.f
src/i2p_pkg.sv
src/i2p_if.sv
src/i2p_ram.sv
src/infix_to_postfix_reorder_top.sv
dv/tb_infix_to_postfix_reorder_top.sv
